FILE: rtl/tsr_pkg.sv
// ============================================================================
// tsr_pkg
// Types, register indexes, codes and fixed constants of the speed ramp core.
// ============================================================================
`default_nettype none

package tsr_pkg;

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 16;
    localparam int SpeedW   = 16;
    localparam int RpmW     = 15;
    localparam int RatioW   = 16;
    localparam int StepW    = 16;
    localparam int PprW     = 15;
    localparam int LimW     = 31;
    localparam int ClampW   = 17;
    localparam int ProdW    = 31;
    localparam int RateW    = 26;
    localparam int RateMagW = 25;
    localparam int FreqW    = 41;
    localparam int StatusW  = 2;

    // truncating division by 60: q = (m * RECIP) >> RECIP_SHIFT, exact for m < 2**30
    localparam int RPM_DIVISOR = 60;
    localparam int RecipW      = 31;
    localparam int RECIP_SHIFT = 36;
    localparam logic [RecipW-1:0] RECIP = RecipW'(((64'd1 << RECIP_SHIFT) + 64'(RPM_DIVISOR) - 64'd1)
                                                  / 64'(RPM_DIVISOR));
    localparam int WideW = ProdW + RecipW;

    localparam logic [CfgIdxW-1:0] REG_RPM_CEILING    = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_RPM_FLOOR      = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_GEAR_RATIO     = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_RAMP_STEP      = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_PULSES_PER_REV = 3'd4;

    localparam logic [RpmW-1:0]   RST_RPM_CEILING    = 15'd1000;
    localparam logic [RpmW-1:0]   RST_RPM_FLOOR      = 15'd0;
    localparam logic [RatioW-1:0] RST_GEAR_RATIO     = 16'd1;
    localparam logic [StepW-1:0]  RST_RAMP_STEP      = 16'd100;
    localparam logic [PprW-1:0]   RST_PULSES_PER_REV = 15'd200;

    localparam logic OP_COMMAND = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    localparam logic [StatusW-1:0] STATUS_MOVING = 2'd0;
    localparam logic [StatusW-1:0] STATUS_DONE   = 2'd1;
    localparam logic [StatusW-1:0] STATUS_STOP   = 2'd2;

    typedef enum logic [1:0] {
        KIND_CMD  = 2'd0,
        KIND_TICK = 2'd1,
        KIND_STOP = 2'd2
    } kind_t;

    typedef struct packed {
        logic [RpmW-1:0]   rpm_ceiling;
        logic [RpmW-1:0]   rpm_floor;
        logic [RatioW-1:0] gear_ratio;
        logic [StepW-1:0]  ramp_step;
        logic [PprW-1:0]   pulses_per_rev;
    } cfg_t;

    typedef struct packed {
        logic                     operation;
        logic signed [SpeedW-1:0] speed_rpm;
        logic                     stop_request;
    } in_word_t;

    typedef struct packed {
        kind_t                   kind;
        logic signed [RateW-1:0] target;
    } cmd_word_t;

    typedef struct packed {
        kind_t                kind;
        logic                 direction;
        logic [RateMagW-1:0]  rate_mag;
    } ramp_word_t;

endpackage

`default_nettype wire

FILE: rtl/tsr_cmd_path.sv
// ============================================================================
// tsr_cmd_path
// Three-stage command path: clamp against scaled limits, scale by pulses per
// revolution, divide by 60 through a reciprocal multiply.
// ============================================================================
`default_nettype none

module tsr_cmd_path (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire tsr_pkg::cfg_t     cfg,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire tsr_pkg::in_word_t in_word,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output tsr_pkg::cmd_word_t     out_word
);
    import tsr_pkg::*;

    logic                     v1_reg, v2_reg, v3_reg;
    logic                     ready1, ready2, ready3;
    kind_t                    kind1_reg, kind2_reg, kind3_reg;
    kind_t                    kind1_next;
    logic signed [ClampW-1:0] clamp1_reg, clamp1_next;
    logic                     neg2_reg;
    logic [ProdW-1:0]         mag2_reg, mag2_next;
    logic signed [RateW-1:0]  target3_reg, target3_next;

    logic [SpeedW-1:0]        abs_in;
    logic [LimW-1:0]          max_lim, min_lim;
    logic signed [ClampW-1:0] max_s, min_s;
    logic [SpeedW-1:0]        abs_clamp;
    logic [WideW-1:0]         wide_prod;
    logic [RateMagW-1:0]      quot;

    assign ready3   = !v3_reg || out_ready;
    assign ready2   = !v2_reg || ready3;
    assign ready1   = !v1_reg || ready2;
    assign in_ready = ready1;

    // stage 1: clamp
    always_comb begin
        abs_in  = in_word.speed_rpm[SpeedW-1] ? SpeedW'(-in_word.speed_rpm)
                                              : SpeedW'(in_word.speed_rpm);
        max_lim = LimW'(cfg.rpm_ceiling) * LimW'(cfg.gear_ratio);
        min_lim = LimW'(cfg.rpm_floor) * LimW'(cfg.gear_ratio);
        max_s   = $signed({{(ClampW-RpmW){1'b0}}, cfg.rpm_ceiling});
        min_s   = $signed({{(ClampW-RpmW){1'b0}}, cfg.rpm_floor});
        if (in_word.speed_rpm == '0) begin
            clamp1_next = '0;
        end else if (LimW'(abs_in) > max_lim) begin
            clamp1_next = in_word.speed_rpm[SpeedW-1] ? -max_s : max_s;
        end else if (LimW'(abs_in) < min_lim) begin
            clamp1_next = in_word.speed_rpm[SpeedW-1] ? -min_s : min_s;
        end else begin
            clamp1_next = ClampW'(in_word.speed_rpm);
        end
        priority if (in_word.stop_request) begin
            kind1_next = KIND_STOP;
        end else if (in_word.operation == OP_TICK) begin
            kind1_next = KIND_TICK;
        end else begin
            kind1_next = KIND_CMD;
        end
    end

    // stage 2: scale magnitude
    always_comb begin
        abs_clamp = clamp1_reg[ClampW-1] ? SpeedW'(-clamp1_reg) : SpeedW'(clamp1_reg);
        mag2_next = ProdW'(abs_clamp) * ProdW'(cfg.pulses_per_rev);
    end

    // stage 3: divide by 60, restore sign
    always_comb begin
        wide_prod    = WideW'(mag2_reg) * WideW'(RECIP);
        quot         = wide_prod[RECIP_SHIFT +: RateMagW];
        target3_next = neg2_reg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (ready1) begin
                v1_reg <= in_valid;
            end
            if (ready2) begin
                v2_reg <= v1_reg;
            end
            if (ready3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ready1) begin
            kind1_reg  <= kind1_next;
            clamp1_reg <= clamp1_next;
        end
        if (ready2) begin
            kind2_reg <= kind1_reg;
            neg2_reg  <= clamp1_reg[ClampW-1];
            mag2_reg  <= mag2_next;
        end
        if (ready3) begin
            kind3_reg   <= kind2_reg;
            target3_reg <= target3_next;
        end
    end

    assign out_valid       = v3_reg;
    assign out_word.kind   = kind3_reg;
    assign out_word.target = target3_reg;

endmodule

`default_nettype wire

FILE: rtl/tsr_ramp_state.sv
// ============================================================================
// tsr_ramp_state
// Ramp state register: takes new targets, steps or snaps the current rate on
// ticks and keeps the last direction.
// ============================================================================
`default_nettype none

module tsr_ramp_state (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [tsr_pkg::StepW-1:0]     ramp_step,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire tsr_pkg::cmd_word_t            in_word,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output tsr_pkg::ramp_word_t                out_word
);
    import tsr_pkg::*;

    logic signed [RateW-1:0] target_reg, target_next;
    logic signed [RateW-1:0] prev_reg, prev_next;
    logic signed [RateW-1:0] cur_reg, cur_next;
    logic                    dir_reg, dir_next;
    logic                    out_v_reg;
    ramp_word_t              out_word_reg, out_word_next;
    logic                    fire;

    logic signed [RateW:0]   diff, step_s, up_sum, dn_sum, cur_x, tgt_x;
    logic [RateW:0]          diff_mag;
    logic                    snap;
    logic signed [RateW-1:0] tick_rate;

    assign in_ready = !out_v_reg || out_ready;
    assign fire     = in_valid && in_ready;

    always_comb begin
        cur_x    = (RateW+1)'(cur_reg);
        tgt_x    = (RateW+1)'(target_reg);
        step_s   = $signed({{(RateW+1-StepW){1'b0}}, ramp_step});
        diff     = tgt_x - (RateW+1)'(prev_reg);
        diff_mag = diff[RateW] ? (RateW+1)'(-diff) : (RateW+1)'(diff);
        up_sum   = cur_x + step_s;
        dn_sum   = cur_x - step_s;
        snap     = (diff_mag < (RateW+1)'(ramp_step)) && (diff != '0);

        prev_next = prev_reg;
        tick_rate = cur_reg;
        if (cur_reg != target_reg) begin
            if (!snap) begin
                prev_next = target_reg;
            end
            if (snap) begin
                tick_rate = target_reg;
            end else if (cur_reg < target_reg) begin
                tick_rate = (up_sum > tgt_x) ? target_reg : up_sum[RateW-1:0];
            end else begin
                tick_rate = (dn_sum < tgt_x) ? target_reg : dn_sum[RateW-1:0];
            end
        end
    end

    always_comb begin
        target_next = target_reg;
        cur_next    = cur_reg;
        dir_next    = dir_reg;
        if (fire) begin
            unique case (in_word.kind)
                KIND_CMD: begin
                    target_next = in_word.target;
                end
                KIND_TICK: begin
                    cur_next = tick_rate;
                    if (tick_rate > 0) begin
                        dir_next = 1'b0;
                    end else if (tick_rate < 0) begin
                        dir_next = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        out_word_next.kind      = in_word.kind;
        out_word_next.direction = dir_next;
        out_word_next.rate_mag  = '0;
        if (in_word.kind == KIND_TICK) begin
            out_word_next.rate_mag = cur_next[RateW-1] ? RateMagW'(-cur_next)
                                                       : RateMagW'(cur_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= '0;
            prev_reg   <= '0;
            cur_reg    <= '0;
            dir_reg    <= 1'b0;
            out_v_reg  <= 1'b0;
        end else begin
            target_reg <= target_next;
            cur_reg    <= cur_next;
            dir_reg    <= dir_next;
            if (fire && in_word.kind == KIND_TICK) begin
                prev_reg <= prev_next;
            end
            if (in_ready) begin
                out_v_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_word_reg <= out_word_next;
        end
    end

    assign out_valid = out_v_reg;
    assign out_word  = out_word_reg;

    a_stop_holds_state: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && in_word.kind == KIND_STOP |=>
            $stable(target_reg) && $stable(prev_reg) && $stable(cur_reg) && $stable(dir_reg))
        else $error("stop word changed ramp state");

    a_settled_tick_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && in_word.kind == KIND_TICK && cur_reg == target_reg |=>
            $stable(cur_reg) && $stable(prev_reg))
        else $error("tick moved a settled ramp");

    a_no_overshoot: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && in_word.kind == KIND_TICK && cur_reg < target_reg |=> cur_reg <= target_reg)
        else $error("ramp overshot target");

endmodule

`default_nettype wire

FILE: rtl/tsr_out_stage.sv
// ============================================================================
// tsr_out_stage
// Result register: drive frequency multiply, status and run enable.
// ============================================================================
`default_nettype none

module tsr_out_stage (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic [tsr_pkg::RatioW-1:0]  gear_ratio,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire tsr_pkg::ramp_word_t         in_word,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [tsr_pkg::StatusW-1:0]      m_status,
    output logic                             m_direction,
    output logic [tsr_pkg::FreqW-1:0]        m_drive_freq,
    output logic                             m_run_enable
);
    import tsr_pkg::*;

    logic                 valid_reg;
    logic [StatusW-1:0]   status_reg, status_next;
    logic                 dir_reg;
    logic [FreqW-1:0]     freq_reg, freq_next, freq_prod;
    logic                 run_reg, run_next;

    assign in_ready = !valid_reg || m_ready;

    always_comb begin
        freq_prod = FreqW'(in_word.rate_mag) * FreqW'(gear_ratio);
        run_next  = (in_word.kind == KIND_TICK) && (in_word.rate_mag != '0)
                    && (gear_ratio != '0);
        freq_next = run_next ? freq_prod : '0;
        unique case (in_word.kind)
            KIND_STOP: status_next = STATUS_STOP;
            KIND_TICK: status_next = run_next ? STATUS_MOVING : STATUS_DONE;
            KIND_CMD:  status_next = STATUS_MOVING;
            default:   status_next = STATUS_MOVING;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            status_reg <= status_next;
            dir_reg    <= in_word.direction;
            freq_reg   <= freq_next;
            run_reg    <= run_next;
        end
    end

    assign m_valid      = valid_reg;
    assign m_status     = status_reg;
    assign m_direction  = dir_reg;
    assign m_drive_freq = freq_reg;
    assign m_run_enable = run_reg;

    a_run_means_moving: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_run_enable |-> m_status == STATUS_MOVING && m_drive_freq != '0)
        else $error("run enable without motion");

    a_stop_is_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STATUS_STOP |-> !m_run_enable && m_drive_freq == '0)
        else $error("stop word drives the motor");

endmodule

`default_nettype wire

FILE: rtl/trapezoidal_speed_ramp_core.sv
// ============================================================================
// trapezoidal_speed_ramp_core
// Stepper speed ramp: speed commands set a clamped target rate, ramp ticks
// move the current rate toward it and report drive frequency and direction.
//
// Input channel (s_valid/s_ready): one word per command or tick; a stop
// request reports a priority stop and leaves the ramp untouched.
// Result channel (m_valid/m_ready): exactly one result word per input word,
// in order.
// Pipeline: input register, three command stages - clamp, scale, divide by
// 60 - ramp state, result register.
// Throughput: one word per cycle while m_ready is high, set by the ramp state.
// Stall: six words can be in flight; s_ready drops only when every stage is
// full and m_ready is low, and nothing is lost or repeated.
// Reset: aresetn (synchronous, active low) empties the pipeline, clears the
// ramp state and loads the register defaults.
// Configuration: cfg_wr_en writes cfg_wr_data to register cfg_addr at once;
// write only while the block holds no words.
// ============================================================================
`default_nettype none

module trapezoidal_speed_ramp_core (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [tsr_pkg::CfgIdxW-1:0]       cfg_addr,
    input  wire logic [tsr_pkg::CfgDataW-1:0]      cfg_wr_data,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_operation,
    input  wire logic signed [tsr_pkg::SpeedW-1:0] s_speed_rpm,
    input  wire logic                              s_stop_request,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [tsr_pkg::StatusW-1:0]            m_status,
    output logic                                   m_direction,
    output logic [tsr_pkg::FreqW-1:0]              m_drive_freq,
    output logic                                   m_run_enable
);
    import tsr_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    logic       in_v_reg;
    in_word_t   in_word_reg;
    logic       cmd_in_ready;
    logic       cmd_valid, cmd_ready;
    cmd_word_t  cmd_word;
    logic       ramp_valid, ramp_ready;
    ramp_word_t ramp_word;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_RPM_CEILING:    cfg_next.rpm_ceiling    = cfg_wr_data[RpmW-1:0];
                REG_RPM_FLOOR:      cfg_next.rpm_floor      = cfg_wr_data[RpmW-1:0];
                REG_GEAR_RATIO:     cfg_next.gear_ratio     = cfg_wr_data[RatioW-1:0];
                REG_RAMP_STEP:      cfg_next.ramp_step      = cfg_wr_data[StepW-1:0];
                REG_PULSES_PER_REV: cfg_next.pulses_per_rev = cfg_wr_data[PprW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rpm_ceiling    <= RST_RPM_CEILING;
            cfg_reg.rpm_floor      <= RST_RPM_FLOOR;
            cfg_reg.gear_ratio     <= RST_GEAR_RATIO;
            cfg_reg.ramp_step      <= RST_RAMP_STEP;
            cfg_reg.pulses_per_rev <= RST_PULSES_PER_REV;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign s_ready = !in_v_reg || cmd_in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
        end else if (s_ready) begin
            in_v_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_word_reg.operation    <= s_operation;
            in_word_reg.speed_rpm    <= s_speed_rpm;
            in_word_reg.stop_request <= s_stop_request;
        end
    end

    tsr_cmd_path u_cmd_path (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (in_v_reg),
        .in_ready  (cmd_in_ready),
        .in_word   (in_word_reg),
        .out_valid (cmd_valid),
        .out_ready (cmd_ready),
        .out_word  (cmd_word)
    );

    tsr_ramp_state u_ramp_state (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ramp_step (cfg_reg.ramp_step),
        .in_valid  (cmd_valid),
        .in_ready  (cmd_ready),
        .in_word   (cmd_word),
        .out_valid (ramp_valid),
        .out_ready (ramp_ready),
        .out_word  (ramp_word)
    );

    tsr_out_stage u_out_stage (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .gear_ratio   (cfg_reg.gear_ratio),
        .in_valid     (ramp_valid),
        .in_ready     (ramp_ready),
        .in_word      (ramp_word),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_direction  (m_direction),
        .m_drive_freq (m_drive_freq),
        .m_run_enable (m_run_enable)
    );

    a_backpressure_only_from_sink: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled while result side drains");

endmodule

`default_nettype wire
